### hw/rtl/smrb_pkg.sv
// Package for the SPI master register block: command and register codes,
// status and control bit masks, and the queued item type.
// Depends on nothing; the front, the back and the top level import it.
`default_nettype none

package smrb_pkg;

  // Bus commands as they arrive on the command port.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLASH = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd1;
  localparam logic [2:0] REG_DATA   = 3'd2;
  localparam logic [2:0] REG_PARAM  = 3'd4;
  localparam logic [2:0] REG_CS     = 3'd5;

  // Status bits.
  localparam logic [7:0] ST_SPIF    = 8'h80;
  localparam logic [7:0] ST_WCOL    = 8'h40;
  localparam logic [7:0] ST_TXFULL  = 8'h08;
  localparam logic [7:0] ST_TXEMPTY = 8'h04;
  localparam logic [7:0] ST_RXFULL  = 8'h02;
  localparam logic [7:0] ST_RXEMPTY = 8'h01;

  // Control and parameter bits.
  localparam logic [7:0] CT_IE    = 8'h80;
  localparam logic [7:0] CT_CLEAR = 8'h40;
  localparam logic [7:0] PM_ME    = 8'h01;

  // Reset values and fixed bytes.
  localparam logic [7:0] STATUS_RESET    = 8'h05;
  localparam logic [7:0] PARAM_RESET     = 8'h01;
  localparam logic [7:0] EMPTY_READ      = 8'hEF;
  localparam logic [7:0] FLASH_READ_OP   = 8'h03;
  localparam logic [7:0] CS_FLASH_ACTIVE = 8'h01;
  localparam logic [7:0] CS_FLASH_IDLE   = 8'h11;

  localparam int          FLASH_AW_MAX   = 24;
  localparam logic [3:0]  FLASH_SIZE_MAX = 4'd8;
  localparam logic [3:0]  HEAD_BYTES     = 4'd4;

  // Operation classes decided by the front.
  typedef enum logic [2:0] {
    OP_REG_READ   = 3'd0,
    OP_DATA_READ  = 3'd1,
    OP_REG_WRITE  = 3'd2,
    OP_DATA_WRITE = 3'd3,
    OP_FLASH      = 3'd4,
    OP_NONE       = 3'd5
  } smrb_op_t;

  typedef struct packed {
    smrb_op_t                  op;
    logic [2:0]                addr;
    logic [7:0]                wdata;
    logic [7:0]                reply;
    logic [FLASH_AW_MAX-1:0]   faddr;
    logic [3:0]                fsize;
    logic [63:0]               fbytes;
  } smrb_item_t;

endpackage

`default_nettype wire

### hw/rtl/smrb_front.sv
// Front end of the SPI master register block: takes bus beats, classifies
// them and holds them in a two-entry queue for the back end.
// Depends on smrb_pkg.
`default_nettype none

module smrb_front import smrb_pkg::*; #(
  parameter int FLASH_ADDR_BITS = 21
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 command,
  input  wire logic [2:0]                 reg_addr,
  input  wire logic [7:0]                 write_data,
  input  wire logic [7:0]                 slave_reply,
  input  wire logic [FLASH_ADDR_BITS-1:0] rom_addr,
  input  wire logic [3:0]                 rom_size,
  input  wire logic [63:0]                rom_slave_bytes,
  output logic                            q_valid,
  output smrb_item_t                      q_item,
  input  wire logic                       q_pop
);

  localparam int QD = 2;
  localparam int QFW = $clog2(QD + 1);

  smrb_item_t       entries [QD];
  logic             head;
  logic             tail;
  logic [QFW-1:0]   fill;
  smrb_item_t       item;
  logic             push;

  always_comb begin
    item.addr   = reg_addr;
    item.wdata  = write_data;
    item.reply  = slave_reply;
    item.faddr  = FLASH_AW_MAX'(rom_addr);
    item.fsize  = (rom_size > FLASH_SIZE_MAX) ? FLASH_SIZE_MAX : rom_size;
    item.fbytes = rom_slave_bytes;
    unique case (command)
      CMD_READ:  item.op = (reg_addr == REG_DATA) ? OP_DATA_READ : OP_REG_READ;
      CMD_WRITE: item.op = (reg_addr == REG_DATA) ? OP_DATA_WRITE : OP_REG_WRITE;
      CMD_FLASH: item.op = OP_FLASH;
      default:   item.op = OP_NONE;
    endcase
  end

  assign busy    = (fill == QFW'(QD));
  assign push    = start && !busy;
  assign q_valid = (fill != '0);
  assign q_item  = entries[head];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      tail <= 1'b0;
      fill <= '0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (q_pop) begin
        head <= ~head;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (q_pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/smrb_back.sv
// Back end of the SPI master register block: register file, receive FIFO
// memory, flash read sequencer and the registered result port.
// Depends on smrb_pkg.
`default_nettype none

module smrb_back import smrb_pkg::*; #(
  parameter int RX_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire smrb_item_t  q_item,
  output logic             q_pop,
  output logic             result_valid,
  output logic [7:0]       read_data,
  output logic [63:0]      rom_data,
  output logic             mosi_valid,
  output logic [7:0]       mosi_byte,
  output logic             chip_select,
  output logic             irq,
  output logic             last
);

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int RX_CW = $clog2(RX_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_FLASH = 3'b100
  } smrb_state_t;

  smrb_state_t       state, state_next;
  smrb_item_t        cur, cur_next;
  logic [3:0]        step, step_next;
  logic [7:0]        regs [8];
  logic [7:0]        regs_next [8];
  logic [RX_CW-1:0]  count, count_next;
  logic [RX_AW-1:0]  rd_ptr, rd_ptr_next;
  logic [RX_AW-1:0]  wr_ptr, wr_ptr_next;
  logic              irq_level, irq_next;
  logic              cs_level, cs_next;

  logic [7:0]        rx_mem [RX_DEPTH];
  logic [7:0]        rx_q;
  logic              mem_we;

  logic              res_valid_next;
  logic [7:0]        rd_next;
  logic [63:0]       rom_next;
  logic              mv_next;
  logic [7:0]        mb_next;
  logic              cs_out_next;
  logic              last_next;

  logic [7:0]        st;
  logic [7:0]        ctl;
  logic              sent;
  logic              touch_irq;
  logic [63:0]       rom_masked;

  // Only the bytes inside the requested size are kept.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rom_masked[8*i +: 8] = (4'(i) < cur.fsize) ? cur.fbytes[8*i +: 8] : 8'h00;
    end
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    step_next      = step;
    regs_next      = regs;
    count_next     = count;
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    irq_next       = irq_level;
    cs_next        = cs_level;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    res_valid_next = 1'b0;
    rd_next        = 8'h00;
    rom_next       = 64'h0;
    mv_next        = 1'b0;
    mb_next        = 8'h00;
    cs_out_next    = cs_level;
    last_next      = 1'b0;
    st             = regs[REG_STATUS];
    ctl            = regs[REG_CTRL];
    sent           = 1'b0;
    touch_irq      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cur_next   = q_item;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next     = S_IDLE;
        res_valid_next = 1'b1;
        last_next      = 1'b1;
        unique case (cur.op)
          OP_REG_READ: begin
            rd_next   = regs[cur.addr];
            touch_irq = 1'b1;
          end
          OP_DATA_READ: begin
            if (count == '0) begin
              rd_next = EMPTY_READ;
            end else begin
              st          = st & ~ST_RXFULL;
              rd_next     = rx_q;
              rd_ptr_next = (rd_ptr == RX_AW'(RX_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
              count_next  = count - 1'b1;
              if (count_next == '0) begin
                st = st | ST_RXEMPTY;
              end
              touch_irq = 1'b1;
            end
          end
          OP_DATA_WRITE: begin
            if (count == RX_CW'(RX_DEPTH)) begin
              st = st | ST_WCOL;
            end else begin
              mem_we      = 1'b1;
              wr_ptr_next = (wr_ptr == RX_AW'(RX_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
              count_next  = count + 1'b1;
              if (count_next == RX_CW'(RX_DEPTH)) begin
                st = st | ST_RXFULL;
              end
            end
            st        = (st & ~(ST_RXEMPTY | ST_TXFULL)) | ST_TXEMPTY;
            sent      = 1'b1;
            mv_next   = 1'b1;
            mb_next   = cur.wdata;
            touch_irq = 1'b1;
          end
          OP_REG_WRITE: begin
            touch_irq = 1'b1;
            unique case (cur.addr)
              REG_CTRL: begin
                if ((cur.wdata & CT_CLEAR) != 8'h00) begin
                  count_next  = '0;
                  rd_ptr_next = '0;
                  wr_ptr_next = '0;
                  st = (st | ST_RXEMPTY | ST_TXEMPTY) & ~(ST_RXFULL | ST_TXFULL);
                end
                ctl = cur.wdata;
              end
              REG_STATUS: begin
                st = cur.wdata & ~ST_SPIF;
              end
              REG_CS: begin
                regs_next[REG_CS] = cur.wdata;
                if ((regs[REG_PARAM] & PM_ME) == 8'h00 && cur.wdata[0]) begin
                  cs_next = cur.wdata[4];
                end
              end
              default: begin
                regs_next[cur.addr] = cur.wdata;
              end
            endcase
          end
          OP_FLASH: begin
            if ((regs[REG_PARAM] & PM_ME) == 8'h00) begin
              rom_next = '1;
            end else begin
              // The sequence runs with the line low; results are formed in S_FLASH.
              res_valid_next    = 1'b0;
              last_next         = 1'b0;
              regs_next[REG_CS] = CS_FLASH_ACTIVE;
              cs_next           = 1'b0;
              step_next         = 4'd0;
              state_next        = S_FLASH;
            end
          end
          default: begin
          end
        endcase
        if (touch_irq) begin
          if (count_next != '0 || sent) begin
            st = st | ST_SPIF;
          end
          irq_next = ((st & ST_SPIF) != 8'h00) && ((ctl & CT_IE) != 8'h00);
        end
        regs_next[REG_STATUS] = st;
        regs_next[REG_CTRL]   = ctl;
        cs_out_next           = cs_next;
      end

      S_FLASH: begin
        res_valid_next = 1'b1;
        cs_out_next    = 1'b0;
        step_next      = step + 1'b1;
        if (step < HEAD_BYTES) begin
          mv_next = 1'b1;
          case (step[1:0])
            2'd0:    mb_next = FLASH_READ_OP;
            2'd1:    mb_next = cur.faddr[23:16];
            2'd2:    mb_next = cur.faddr[15:8];
            default: mb_next = cur.faddr[7:0];
          endcase
        end else if (step < HEAD_BYTES + cur.fsize) begin
          mv_next = 1'b1;
        end else begin
          rom_next          = rom_masked;
          regs_next[REG_CS] = CS_FLASH_IDLE;
          cs_next           = 1'b1;
          cs_out_next       = 1'b1;
          last_next         = 1'b1;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Receive store: one write port, registered read at the read pointer.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rx_mem[wr_ptr] <= cur.reply;
    end
    rx_q <= rx_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    cur         <= cur_next;
    step        <= step_next;
    read_data   <= rd_next;
    rom_data    <= rom_next;
    mosi_valid  <= mv_next;
    mosi_byte   <= mb_next;
    chip_select <= cs_out_next;
    irq         <= irq_next;
    last        <= last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      for (int i = 0; i < 8; i++) begin
        if (3'(i) == REG_STATUS) begin
          regs[i] <= STATUS_RESET;
        end else if (3'(i) == REG_PARAM) begin
          regs[i] <= PARAM_RESET;
        end else begin
          regs[i] <= 8'h00;
        end
      end
      count        <= '0;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      irq_level    <= 1'b0;
      cs_level     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      regs         <= regs_next;
      count        <= count_next;
      rd_ptr       <= rd_ptr_next;
      wr_ptr       <= wr_ptr_next;
      irq_level    <= irq_next;
      cs_level     <= cs_next;
      result_valid <= res_valid_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/spi_master_register_block_unit.sv
// Top level of the SPI master register block: front end with item queue
// feeding the execution back end. Depends on smrb_pkg, smrb_front, smrb_back.
//
//   channel   handshake                 fields
//   command   start / busy              command reg_addr write_data slave_reply
//                                       rom_addr rom_size rom_slave_bytes
//   result    result_valid (strobe)     read_data rom_data mosi_valid mosi_byte
//                                       chip_select irq last
//
// A beat is taken when start is high and busy is low; two beats can wait in
// the queue while the back end works. Register reads and writes each pass
// through a fetch from the queue, then execute against the register file
// and the receive store read port. An enabled flash read runs fetch,
// setup, then one result per cycle for the four header bytes, the data
// bytes and the final assembled value.
// Reset is synchronous; results appear in the cycle after they are formed
// and hold for a single cycle, as the receiver cannot stall.
`default_nettype none

module spi_master_register_block_unit import smrb_pkg::*; #(
  parameter int RX_DEPTH        = 256,
  parameter int FLASH_ADDR_BITS = 21
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 command,
  input  wire logic [2:0]                 reg_addr,
  input  wire logic [7:0]                 write_data,
  input  wire logic [7:0]                 slave_reply,
  input  wire logic [FLASH_ADDR_BITS-1:0] rom_addr,
  input  wire logic [3:0]                 rom_size,
  input  wire logic [63:0]                rom_slave_bytes,
  output logic                            result_valid,
  output logic [7:0]                      read_data,
  output logic [63:0]                     rom_data,
  output logic                            mosi_valid,
  output logic [7:0]                      mosi_byte,
  output logic                            chip_select,
  output logic                            irq,
  output logic                            last
);

  logic       q_valid;
  logic       q_pop;
  smrb_item_t q_item;

  smrb_front #(
    .FLASH_ADDR_BITS(FLASH_ADDR_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .reg_addr        (reg_addr),
    .write_data      (write_data),
    .slave_reply     (slave_reply),
    .rom_addr        (rom_addr),
    .rom_size        (rom_size),
    .rom_slave_bytes (rom_slave_bytes),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  smrb_back #(
    .RX_DEPTH(RX_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .read_data    (read_data),
    .rom_data     (rom_data),
    .mosi_valid   (mosi_valid),
    .mosi_byte    (mosi_byte),
    .chip_select  (chip_select),
    .irq          (irq),
    .last         (last)
  );

endmodule

`default_nettype wire
